// File: rtl/core/rldr_pkg.sv
// ----------------------------------------------------------------------------
// rldr_pkg
// Shared constants and types for the radial lens distortion remap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rldr_pkg;

  // Image size limit and radius precision.
  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int COL_W   = 12;
  localparam int COLOR_W = 32;
  localparam int COEF_W  = 16;
  localparam int DIM_W   = 13;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // Datapath widths.
  localparam int OFS_W  = DIM_W + 1;            // doubled offset from center
  localparam int D_W    = 2 * OFS_W;            // squared distance
  localparam int R_W    = 2 * DIM_W;            // squared corner radius
  localparam int REM_W  = D_W + 1;              // division remainder
  localparam int Q_W    = 2 * FRAC_BITS + 2;    // ratio D/R with fraction
  localparam int RS_W   = FRAC_BITS + 1;        // normalized radius
  localparam int P_W    = COEF_W + 6;           // Horner accumulator
  localparam int PROD_W = P_W + RS_W + 1;
  localparam int XP_W   = P_W + OFS_W;
  localparam int XS_W   = XP_W + 2;

  // Pipeline depths of the radius unit.
  localparam int DIV_STEPS  = Q_W;
  localparam int SQRT_STEPS = RS_W;
  localparam int RAD_LAT    = DIV_STEPS + SQRT_STEPS;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_COEF_CUBIC    = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_SQUARE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_LINEAR   = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_CONSTANT = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd4;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd5;

  // Reset values.
  localparam logic [COEF_W-1:0] COEF_ONE     = 16'd4096;
  localparam logic [DIM_W-1:0]  RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]  RESET_HEIGHT = 13'd480;

  // Side data that travels alongside the radius unit.
  typedef struct packed {
    logic [COLOR_W-1:0]      color;
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
  } side_t;

endpackage

`default_nettype wire

// File: rtl/core/rldr_if.sv
// ----------------------------------------------------------------------------
// rldr_in_if / rldr_out_if
// Valid/ready channels for source pixels and remapped results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rldr_in_if
  import rldr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   src_col;
  logic [COL_W-1:0]   src_row;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, src_col, src_row, pixel_color, input ready);
  modport sink (input valid, src_col, src_row, pixel_color, output ready);
endinterface

interface rldr_out_if
  import rldr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   dest_col;
  logic [COL_W-1:0]   dest_row;
  logic               in_range;
  logic [COLOR_W-1:0] color_out;

  modport source (output valid, dest_col, dest_row, in_range, color_out, input ready);
  modport sink (input valid, dest_col, dest_row, in_range, color_out, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rldr_radius.sv
// ----------------------------------------------------------------------------
// rldr_radius
// Pipelined normalized radius: rs = isqrt(floor(D * 2^(2F) / R)), one
// restoring division bit per stage followed by one square-root digit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rldr_radius
  import rldr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [D_W-1:0]  d,
  input  wire logic [R_W-1:0]  r,
  input  wire logic            sat,
  output logic                 out_valid,
  output logic                 out_sat,
  output logic [RS_W-1:0]      rs
);

  logic [REM_W-1:0] div_rem [DIV_STEPS];
  logic [Q_W-1:0]   div_q   [DIV_STEPS];
  logic             div_v   [DIV_STEPS];
  logic             div_sat [DIV_STEPS];
  logic [Q_W-1:0]   sq_x    [SQRT_STEPS];
  logic [Q_W-1:0]   sq_res  [SQRT_STEPS];
  logic             sq_v    [SQRT_STEPS];
  logic             sq_sat  [SQRT_STEPS];

  logic [REM_W-1:0] div_rem_next [DIV_STEPS];
  logic [Q_W-1:0]   div_q_next   [DIV_STEPS];
  logic [Q_W-1:0]   sq_x_next    [SQRT_STEPS];
  logic [Q_W-1:0]   sq_res_next  [SQRT_STEPS];

  // Division stages: the first two produce the integer bits of D/R, the rest
  // shift the remainder and produce one fraction bit each.
  always_comb begin
    logic [REM_W-1:0] rem_in;
    logic [Q_W-1:0]   q_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] cmp;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_in = (i == 0) ? REM_W'(d) : div_rem[(i == 0) ? 0 : i - 1];
      q_in   = (i == 0) ? '0 : div_q[(i == 0) ? 0 : i - 1];
      rem_sh = (i >= 2) ? (rem_in << 1) : rem_in;
      cmp    = (i == 0) ? (REM_W'(r) << 1) : REM_W'(r);
      if (rem_sh >= cmp) begin
        div_rem_next[i] = rem_sh - cmp;
        div_q_next[i]   = {q_in[Q_W-2:0], 1'b1};
      end else begin
        div_rem_next[i] = rem_sh;
        div_q_next[i]   = {q_in[Q_W-2:0], 1'b0};
      end
    end
  end

  // Square-root stages: one result bit per stage, from the top digit down.
  always_comb begin
    logic [Q_W-1:0] x_in;
    logic [Q_W-1:0] res_in;
    logic [Q_W-1:0] dbit;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      x_in   = (k == 0) ? div_q[DIV_STEPS-1] : sq_x[(k == 0) ? 0 : k - 1];
      res_in = (k == 0) ? '0 : sq_res[(k == 0) ? 0 : k - 1];
      dbit   = Q_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      if (x_in >= res_in + dbit) begin
        sq_x_next[k]   = x_in - (res_in + dbit);
        sq_res_next[k] = (res_in >> 1) + dbit;
      end else begin
        sq_x_next[k]   = x_in;
        sq_res_next[k] = res_in >> 1;
      end
    end
  end

  // Valid bits travel with the data and are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STEPS; i++) div_v[i] <= 1'b0;
      for (int k = 0; k < SQRT_STEPS; k++) sq_v[k] <= 1'b0;
    end else if (en) begin
      div_v[0] <= in_valid;
      for (int i = 1; i < DIV_STEPS; i++) div_v[i] <= div_v[i-1];
      sq_v[0] <= div_v[DIV_STEPS-1];
      for (int k = 1; k < SQRT_STEPS; k++) sq_v[k] <= sq_v[k-1];
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      div_sat[0] <= sat;
      for (int i = 0; i < DIV_STEPS; i++) begin
        div_rem[i] <= div_rem_next[i];
        div_q[i]   <= div_q_next[i];
      end
      for (int i = 1; i < DIV_STEPS; i++) div_sat[i] <= div_sat[i-1];
      sq_sat[0] <= div_sat[DIV_STEPS-1];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sq_x[k]   <= sq_x_next[k];
        sq_res[k] <= sq_res_next[k];
      end
      for (int k = 1; k < SQRT_STEPS; k++) sq_sat[k] <= sq_sat[k-1];
    end
  end

  // A radius of twice the corner radius or more saturates.
  assign out_valid = sq_v[SQRT_STEPS-1];
  assign out_sat   = sq_sat[SQRT_STEPS-1];
  assign rs        = out_sat ? '1 : sq_res[SQRT_STEPS-1][RS_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/radial_lens_distortion_remap_top.sv
// ----------------------------------------------------------------------------
// radial_lens_distortion_remap_top
// Pipeline from an accepted source word to its result word:
// 3 offset/distance stages, 51 radius stages, 6 Horner stages, 2 output stages.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset clears all valid bits and loads the default configuration
// (identity coefficients, 640 x 480 image); there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_lens_distortion_remap_top
  import rldr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  rldr_in_if.sink               pix_in,
  rldr_out_if.source            pix_out
);

  localparam int HORN_STAGES = 6;
  localparam int SIDE_LEN    = RAD_LAT + HORN_STAGES;

  // Configuration registers.
  logic [COEF_W-1:0] coef_cubic;
  logic [COEF_W-1:0] coef_square;
  logic [COEF_W-1:0] coef_linear;
  logic [COEF_W-1:0] coef_constant;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_cubic    <= '0;
      coef_square   <= '0;
      coef_linear   <= '0;
      coef_constant <= COEF_ONE;
      image_width   <= RESET_WIDTH;
      image_height  <= RESET_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COEF_CUBIC:    coef_cubic    <= cfg_data;
        REG_COEF_SQUARE:   coef_square   <= cfg_data;
        REG_COEF_LINEAR:   coef_linear   <= cfg_data;
        REG_COEF_CONSTANT: coef_constant <= cfg_data;
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated image size.
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic             zero_dim;

  assign w        = (image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width;
  assign h        = (image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height;
  assign zero_dim = (w == '0) || (h == '0);

  // The whole pipeline moves when the output register can take a word.
  logic adv;
  logic out_valid;

  assign adv          = !out_valid || pix_out.ready;
  assign pix_in.ready = adv;

  // Stage 0: doubled offsets from the image center.
  logic                    v0;
  logic signed [OFS_W-1:0] dx0, dy0;
  logic [COLOR_W-1:0]      color0;

  // Stage 1: squared offsets and squared corner radius.
  logic                    v1;
  logic [D_W-1:0]          dxs1, dys1;
  logic [R_W-1:0]          r1;
  side_t                   side1;

  // Stage 2: squared distance and the saturation test.
  logic                    v2;
  logic [D_W-1:0]          d2;
  logic [R_W-1:0]          r2;
  logic                    sat2;
  side_t                   side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= pix_in.valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [D_W-1:0] sx;
    logic signed [D_W-1:0] sy;
    if (adv) begin
      dx0    <= $signed({1'b0, pix_in.src_col, 1'b0}) - $signed({1'b0, w});
      dy0    <= $signed({1'b0, pix_in.src_row, 1'b0}) - $signed({1'b0, h});
      color0 <= pix_in.pixel_color;

      sx    = dx0 * dx0;
      sy    = dy0 * dy0;
      dxs1  <= D_W'(sx);
      dys1  <= D_W'(sy);
      r1    <= R_W'(w) * R_W'(w) + R_W'(h) * R_W'(h);
      side1 <= '{color: color0, dx: dx0, dy: dy0};

      d2    <= dxs1 + dys1;
      sat2  <= ({1'b0, dxs1 + dys1} >= {1'b0, r1, 2'b00});
      r2    <= r1;
      side2 <= side1;
    end
  end

  // Normalized radius.
  logic             rad_valid;
  logic             rad_sat;
  logic [RS_W-1:0]  rs;

  rldr_radius u_radius (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v2),
    .d         (d2),
    .r         (r2),
    .sat       (sat2),
    .out_valid (rad_valid),
    .out_sat   (rad_sat),
    .rs        (rs)
  );

  // Side data waits in a delay line until the Horner result is ready.
  side_t side_line [SIDE_LEN];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_line[0] <= side2;
      for (int i = 1; i < SIDE_LEN; i++) side_line[i] <= side_line[i-1];
    end
  end

  // Horner evaluation: a multiply stage and a shift-add stage for each coefficient after the cubic one.
  logic signed [RS_W:0]    rs_s;
  logic signed [P_W-1:0]   p0;
  logic signed [PROD_W-1:0] m1, m2, m3;
  logic signed [P_W-1:0]   p1, p2, p3;
  logic [RS_W-1:0]         rs1, rs2, rs3, rs4;
  logic                    hv [HORN_STAGES];

  assign rs_s = $signed({1'b0, rs});
  assign p0   = P_W'($signed(coef_cubic));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HORN_STAGES; i++) hv[i] <= 1'b0;
    end else if (adv) begin
      hv[0] <= rad_valid;
      for (int i = 1; i < HORN_STAGES; i++) hv[i] <= hv[i-1];
    end
  end

  // The radius is delayed so that it meets its own partial sum at each multiply.
  always_ff @(posedge clk) begin
    if (adv) begin
      m1  <= p0 * rs_s;
      rs1 <= rs;
      rs2 <= rs1;
      rs3 <= rs2;
      rs4 <= rs3;
      p1  <= P_W'(m1 >>> FRAC_BITS) + P_W'($signed(coef_square));
      m2  <= p1 * $signed({1'b0, rs2});
      p2  <= P_W'(m2 >>> FRAC_BITS) + P_W'($signed(coef_linear));
      m3  <= p2 * $signed({1'b0, rs4});
      p3  <= P_W'(m3 >>> FRAC_BITS) + P_W'($signed(coef_constant));
    end
  end

  // Scaled offsets.
  logic                    fv;
  logic signed [XP_W-1:0]  xprod, yprod;
  logic [COLOR_W-1:0]      fcolor;

  always_ff @(posedge clk) begin
    if (rst) fv <= 1'b0;
    else if (adv) fv <= hv[HORN_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xprod  <= p3 * side_line[SIDE_LEN-1].dx;
      yprod  <= p3 * side_line[SIDE_LEN-1].dy;
      fcolor <= side_line[SIDE_LEN-1].color;
    end
  end

  // Add the rounded center, floor and bounds check.
  logic signed [XS_W-1:0] xs, ys;
  logic signed [XS_W-1:0] xc, yc;
  logic                   ok;

  assign xs = XS_W'(xprod) + XS_W'($signed({1'b0, OFS_W'(w) + OFS_W'(1), 12'b0}));
  assign ys = XS_W'(yprod) + XS_W'($signed({1'b0, OFS_W'(h) + OFS_W'(1), 12'b0}));
  assign xc = xs >>> 13;
  assign yc = ys >>> 13;
  assign ok = (xc >= 0) && (yc >= 0)
           && (xc < XS_W'($signed({1'b0, w}))) && (yc < XS_W'($signed({1'b0, h})));

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= fv;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_out.color_out <= fcolor;
      if (zero_dim) begin
        pix_out.dest_col <= '0;
        pix_out.dest_row <= '0;
        pix_out.in_range <= 1'b0;
      end else begin
        pix_out.dest_col <= xc[COL_W-1:0];
        pix_out.dest_row <= yc[COL_W-1:0];
        pix_out.in_range <= ok;
      end
    end
  end

  assign pix_out.valid = out_valid;

  // An in-range word always addresses a pixel inside the image.
  a_in_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && pix_out.in_range |->
      ({1'b0, pix_out.dest_col} < w) && ({1'b0, pix_out.dest_row} < h))
    else $error("in-range word outside the image");

  // A zero image size never produces an in-range word.
  a_zero_dim: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_dim |-> !pix_out.in_range)
    else $error("in-range word with zero image size");

  // A saturated radius reaches the Horner stages as all ones.
  a_rad_sat: assert property (@(posedge clk) disable iff (rst)
    rad_valid && rad_sat |-> (rs == '1))
    else $error("saturated radius not all ones");

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Radial lens distortion remap testbench
// Streams source pixels through the remap block under several coefficient and
// image size settings. Each accepted word is predicted in fixed point or
// carries a directed expectation, and each result word is checked in order
// against the oldest expectation. Both channels idle at random, and once the
// output holds off long enough to stall the input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import rldr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 62;
  localparam int WATCHDOG = 5000;

  typedef struct {
    logic [COL_W-1:0]   col;
    logic [COL_W-1:0]   row;
    logic               inr;
    logic [COLOR_W-1:0] color;
  } landing_t;

  typedef struct {
    logic [COL_W-1:0]   col;
    logic [COL_W-1:0]   row;
    logic [COLOR_W-1:0] color;
    bit                 typed;
    landing_t           want;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  rldr_in_if  pix_in_ch ();
  rldr_out_if pix_out_ch ();

  radial_lens_distortion_remap_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in_ch),
    .pix_out   (pix_out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic signed [COEF_W-1:0] coef_q [4];
  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;

  landing_t landings_due [$];
  int mismatches = 0;
  int words_taken = 0;
  int idle_cycles = 0;

  // Computes where a source pixel lands under the current configuration.
  function automatic landing_t predict_landing(logic [COL_W-1:0] col,
                                               logic [COL_W-1:0] row,
                                               logic [COLOR_W-1:0] color);
    landing_t res;
    longint w, h, dx2, dy2, p, xc, yc, rs, t;
    longint unsigned d, r, q;
    res.color = color;
    w = (img_w > MAX_DIM) ? MAX_DIM : longint'(img_w);
    h = (img_h > MAX_DIM) ? MAX_DIM : longint'(img_h);
    if (w == 0 || h == 0) begin
      res.col = '0;
      res.row = '0;
      res.inr = 1'b0;
      return res;
    end
    dx2 = 2 * longint'(col) - w;
    dy2 = 2 * longint'(row) - h;
    d = dx2 * dx2 + dy2 * dy2;
    r = w * w + h * h;
    // Normalized radius with 16 fraction bits, saturated far from center.
    if (d >= 4 * r) begin
      rs = (longint'(1) << (FRAC_BITS + 1)) - 1;
    end else begin
      q = (d << (2 * FRAC_BITS)) / r;
      rs = 0;
      for (int b = FRAC_BITS; b >= 0; b--) begin
        t = rs | (longint'(1) << b);
        if (longint'(t * t) <= longint'(q)) rs = t;
      end
    end
    // Polynomial in Horner form, floored after every product.
    p = longint'(coef_q[0]);
    p = ((p * rs) >>> FRAC_BITS) + longint'(coef_q[1]);
    p = ((p * rs) >>> FRAC_BITS) + longint'(coef_q[2]);
    p = ((p * rs) >>> FRAC_BITS) + longint'(coef_q[3]);
    xc = (p * dx2 + (w + 1) * 4096) >>> 13;
    yc = (p * dy2 + (h + 1) * 4096) >>> 13;
    res.col = xc[COL_W-1:0];
    res.row = yc[COL_W-1:0];
    res.inr = (xc >= 0 && yc >= 0 && xc < w && yc < h);
    return res;
  endfunction

  // Writes one register and updates the shadow copy; configure drains the pipeline first.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_COEF_CUBIC:    coef_q[0] = val;
      REG_COEF_SQUARE:   coef_q[1] = val;
      REG_COEF_LINEAR:   coef_q[2] = val;
      REG_COEF_CONSTANT: coef_q[3] = val;
      REG_IMAGE_WIDTH:   img_w = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT:  img_h = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b, logic [CFG_W-1:0] c,
                           logic [CFG_W-1:0] d, logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait (landings_due.size() == 0);
    repeat (LATENCY + 8) @(posedge clk);
    write_reg(REG_COEF_CUBIC, a);
    write_reg(REG_COEF_SQUARE, b);
    write_reg(REG_COEF_LINEAR, c);
    write_reg(REG_COEF_CONSTANT, d);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Offers one word and records its expected landing when it is taken.
  task automatic send_pixel(pixel_row_t px);
    @(negedge clk);
    pix_in_ch.valid       <= 1'b1;
    pix_in_ch.src_col     <= px.col;
    pix_in_ch.src_row     <= px.row;
    pix_in_ch.pixel_color <= px.color;
    do @(posedge clk); while (!pix_in_ch.ready);
    landings_due.push_back(px.typed ? px.want : predict_landing(px.col, px.row, px.color));
  endtask

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      pix_in_ch.valid <= 1'b0;
    end
  endtask

  function automatic pixel_row_t random_pixel();
    pixel_row_t px;
    px.typed = 0;
    px.color = $urandom;
    if ($urandom_range(9) < 7 && img_w != 0 && img_h != 0) begin
      px.col = COL_W'($urandom_range((img_w > MAX_DIM ? MAX_DIM : img_w) - 1));
      px.row = COL_W'($urandom_range((img_h > MAX_DIM ? MAX_DIM : img_h) - 1));
    end else begin
      px.col = COL_W'($urandom);
      px.row = COL_W'($urandom);
    end
    return px;
  endfunction

  function automatic pixel_row_t plain(int col, int row, logic [COLOR_W-1:0] color);
    pixel_row_t px;
    px.col = COL_W'(col);
    px.row = COL_W'(row);
    px.color = color;
    px.typed = 0;
    return px;
  endfunction

  function automatic pixel_row_t typed(int col, int row, logic [COLOR_W-1:0] color, bit inr);
    pixel_row_t px;
    px = plain(col, row, color);
    px.typed = 1;
    px.want.col = COL_W'(col);
    px.want.row = COL_W'(row);
    px.want.inr = inr;
    px.want.color = color;
    return px;
  endfunction

  // Receiver: a rotating stall pattern, clean stretches, and one long hold-off.
  initial begin
    logic [15:0] stall_mask;
    int hold;
    int step;
    bit held_once;
    stall_mask = '0;
    hold = 0;
    step = 0;
    held_once = 0;
    pix_out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && words_taken >= 400) begin
        held_once = 1;
        hold = 300;
      end
      if (step % 64 == 0)
        stall_mask = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
      step++;
      if (hold > 0) begin
        hold--;
        pix_out_ch.ready <= 1'b0;
      end else begin
        pix_out_ch.ready <= !stall_mask[step % 16];
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    landing_t want;
    if (!rst && pix_out_ch.valid && pix_out_ch.ready) begin
      if (landings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word with nothing expected: col %0d row %0d",
                   pix_out_ch.dest_col, pix_out_ch.dest_row);
      end else begin
        want = landings_due.pop_front();
        if (pix_out_ch.dest_col !== want.col || pix_out_ch.dest_row !== want.row ||
            pix_out_ch.in_range !== want.inr || pix_out_ch.color_out !== want.color) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected col %0d row %0d in %0b color %h, got %0d %0d %0b %h",
                     want.col, want.row, want.inr, want.color, pix_out_ch.dest_col,
                     pix_out_ch.dest_row, pix_out_ch.in_range, pix_out_ch.color_out);
        end
      end
    end
  end

  // Watchdog on cycles where neither channel moves a word.
  always @(posedge clk) begin
    if (pix_in_ch.valid && pix_in_ch.ready) words_taken++;
    if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    pixel_row_t directed [$];
    pixel_row_t px;
    int burst;
    bit steady;
    pix_in_ch.valid = 1'b0;
    pix_in_ch.src_col = '0;
    pix_in_ch.src_row = '0;
    pix_in_ch.pixel_color = '0;
    coef_q[0] = '0;
    coef_q[1] = '0;
    coef_q[2] = '0;
    coef_q[3] = COEF_ONE;
    img_w = RESET_WIDTH;
    img_h = RESET_HEIGHT;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity mapping after reset: every pixel lands on itself.
    directed = '{typed(0, 0, 32'h0000_0000, 1), typed(639, 479, 32'hFFFF_FFFF, 1),
                 typed(640, 0, 32'hA5A5_A5A5, 0), typed(0, 480, 32'h5A5A_5A5A, 0),
                 typed(4095, 4095, 32'h8000_0001, 0), typed(320, 240, 32'h0012_3456, 1),
                 typed(639, 0, 32'h7FFF_FFFE, 1), typed(2730, 1365, 32'h00FF_00FF, 0)};
    foreach (directed[i]) send_pixel(directed[i]);
    idle_input(1);

    // Coefficient extremes on a tiny image; far pixels saturate the radius.
    configure(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1, 1);
    send_pixel(plain(0, 0, 32'h1));
    send_pixel(plain(4095, 4095, 32'h2));
    send_pixel(plain(4095, 0, 32'h3));
    idle_input(1);
    configure(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 4096, 4096);
    send_pixel(plain(0, 0, 32'h4));
    send_pixel(plain(4095, 4095, 32'h5));
    send_pixel(plain(2048, 2048, 32'h6));
    idle_input(1);
    // Zero width gives no landing; oversize sizes clamp to the maximum.
    configure(0, 0, 0, 16'h1000, 0, 480);
    send_pixel(plain(10, 10, 32'h7));
    send_pixel(plain(4095, 4095, 32'h8));
    idle_input(1);
    configure(16'h0100, 16'hFF00, 16'h0200, 16'h1000, 16'h1FFF, 5000);
    send_pixel(plain(4095, 4095, 32'h9));
    send_pixel(plain(0, 4095, 32'hA));
    send_pixel(plain(1000, 3000, 32'hB));
    idle_input(1);

    // Random phases: mostly mild lens settings, occasionally anything.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2)
        configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(8191)), 16'($urandom_range(8191)));
      else
        configure(16'($signed($urandom_range(2048)) - 1024),
                  16'($signed($urandom_range(2048)) - 1024),
                  16'($signed($urandom_range(2048)) - 1024),
                  16'(3072 + $urandom_range(2048)),
                  16'($urandom_range(4096, 1)), 16'($urandom_range(4096, 1)));
      steady = (ph % 4 == 1);
      burst = 0;
      for (int n = 0; n < 150; n++) begin
        if (!steady && burst == 0) begin
          idle_input($urandom_range(4) == 0 ? $urandom_range(20, 5) : $urandom_range(3));
          burst = $urandom_range(30, 1);
        end
        burst--;
        px = random_pixel();
        send_pixel(px);
      end
      idle_input(1);
    end

    wait (landings_due.size() == 0);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/rldr_pkg.sv
rtl/core/rldr_if.sv
rtl/core/rldr_radius.sv
rtl/core/radial_lens_distortion_remap_top.sv
test/testbench.sv
